// File: rtl/nsfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsfe_pkg
// Shared types, constants and lookup functions of the NMEA sentence field
// extractor.
// ----------------------------------------------------------------------------
package nsfe_pkg;

  // Longest field that is passed on; later characters of a field are dropped
  localparam int MaxFieldChars = 16;
  localparam int OffW          = $clog2(MaxFieldChars + 1);

  localparam int ByteW  = 8;
  localparam int FieldW = 4;
  localparam int HdrW   = 3;
  localparam int KindW  = 2;

  // Header positions
  localparam logic [HdrW-1:0] HdrTagLen = 3'd6;  // characters in a tag
  localparam logic [HdrW-1:0] HdrSatLen = 3'd7;  // header length saturation

  localparam logic [FieldW-1:0] FieldMax = 4'd15;

  localparam logic [ByteW-1:0] CharComma = 8'h2C;

  // Sentence kinds
  typedef enum logic [KindW-1:0] {
    KIND_RMC    = 2'd0,
    KIND_GGA    = 2'd1,
    KIND_VTG    = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  // Result kinds
  localparam logic ITEM_CHAR = 1'b0;
  localparam logic ITEM_END  = 1'b1;

  localparam int ResultsPerByte = 2;
  localparam int QueueDepth     = 4;
  localparam int QPtrW          = $clog2(QueueDepth);
  localparam int QCntW          = $clog2(QueueDepth + 1);

  // Per-sentence state
  typedef struct packed {
    logic [FieldW-1:0] comma_count;
    logic [OffW-1:0]   offset_in_field;
    logic [HdrW-1:0]   header_length;
    logic              header_still_matches;
    logic              drop_seen;
  } sent_state_t;

  // One result item
  typedef struct packed {
    logic              item_kind;
    logic [FieldW-1:0] field_number;
    logic [3:0]        char_offset;
    logic [ByteW-1:0]  field_byte;
    logic              accepted;
    logic              overflowed;
    logic              last_of_run;
  } result_t;

  // Expected tag character at a header position (0..5)
  function automatic logic [ByteW-1:0] tag_char(input kind_t kind,
                                                input logic [HdrW-1:0] pos);
    logic [ByteW-1:0] c;
    c = 8'h00;
    unique case (pos)
      3'd0: c = 8'h24;  // '$'
      3'd1: c = 8'h47;  // 'G'
      3'd2: c = 8'h50;  // 'P'
      3'd3: begin
        unique case (kind)
          KIND_RMC: c = 8'h52;  // 'R'
          KIND_GGA: c = 8'h47;  // 'G'
          KIND_VTG: c = 8'h56;  // 'V'
          default:  c = 8'h00;
        endcase
      end
      3'd4: begin
        unique case (kind)
          KIND_RMC: c = 8'h4D;  // 'M'
          KIND_GGA: c = 8'h47;  // 'G'
          KIND_VTG: c = 8'h54;  // 'T'
          default:  c = 8'h00;
        endcase
      end
      3'd5: begin
        unique case (kind)
          KIND_RMC: c = 8'h43;  // 'C'
          KIND_GGA: c = 8'h41;  // 'A'
          KIND_VTG: c = 8'h47;  // 'G'
          default:  c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Fields passed on for each sentence kind
  function automatic logic field_mapped(input kind_t kind,
                                        input logic [FieldW-1:0] field);
    logic [15:0] map;
    map = 16'h0000;
    unique case (kind)
      KIND_RMC: map = 16'h03FE;  // fields 1-9
      KIND_GGA: map = 16'h0BFE;  // fields 1-9 and 11
      KIND_VTG: map = 16'h00AA;  // fields 1, 3, 5, 7
      default:  map = 16'h0000;
    endcase
    return map[field];
  endfunction

endpackage

// File: rtl/nmea_sentence_field_extractor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_field_extractor_unit
// Streams NMEA sentence bytes in and emits tagged field characters plus an
// end-of-sentence marker carrying header acceptance and overflow status.
// ----------------------------------------------------------------------------
// One sentence byte is taken per cycle while in_tready is high. Bytes before the
// first comma form the header, checked as a prefix of the selected tag ($GPRMC,
// $GPGGA or $GPVTG); an empty header matches, and sentence kind 3 never matches.
// Each non-comma byte of a mapped field (RMC 1-9, GGA 1-9 and 11, VTG 1, 3, 5,
// 7) comes out with its field number (saturating at 15) and its offset within
// the field; characters at offset 16 and beyond are dropped and flagged. The
// byte with in_tlast set also yields an end marker (out_tuser high) that reports
// acceptance and overflow, and the per-sentence state starts over. Rate: the
// byte logic is a single pass from the state registers into a four-entry result
// queue, so one byte is accepted every cycle while each byte makes at most one
// result and out_tready stays high; a final byte that makes both a field
// character and the end marker is absorbed by the queue. in_tready drops only
// while the queue holds more than two results. Throughput is bounded by the
// single result per cycle leaving the queue. Write sentence_kind through
// cfg_wr_en/cfg_wr_data only between sentences with no results pending.
// ----------------------------------------------------------------------------
module nmea_sentence_field_extractor_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: sentence_kind (0 RMC, 1 GGA, 2 VTG)
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  // Byte stream in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_sentence
  // Result stream out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] field_number, [7:4] char_offset,
                                  // [15:8] field_byte, [16] accepted,
                                  // [17] overflowed, [23:18] zero
  output logic        out_tuser,  // item_kind: 0 field character, 1 end marker
  output logic        out_tlast   // last_of_run
);
  import nsfe_pkg::*;

  kind_t       kind_r;
  sent_state_t state_r;
  sent_state_t state_nxt;
  result_t     step_res [ResultsPerByte];
  logic [1:0]  step_cnt;
  logic [1:0]  push_cnt;
  logic        in_xfer;
  logic        room_ok;
  result_t     head;

  assign in_tready = room_ok;
  assign in_xfer   = in_tvalid && room_ok;

  // Hold sentence kind; the user writes it only while idle (not enforced by the block)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_RMC;
    end else if (cfg_wr_en) begin
      kind_r <= kind_t'(cfg_wr_data);
    end
  end

  nsfe_step u_step (
    .kind    (kind_r),
    .cur     (state_r),
    .in_char (in_tdata),
    .eos     (in_tlast),
    .nxt     (state_nxt),
    .res     (step_res),
    .res_cnt (step_cnt)
  );

  // Advance the per-sentence state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r                      <= '0;
      state_r.header_still_matches <= 1'b1;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  assign push_cnt = in_xfer ? step_cnt : 2'd0;

  nsfe_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_res   (step_res),
    .push_cnt   (push_cnt),
    .room_ok    (room_ok),
    .head_valid (out_tvalid),
    .head       (head),
    .pop        (out_tready)
  );

  assign out_tdata = {6'd0, head.overflowed, head.accepted, head.field_byte,
                      head.char_offset, head.field_number};
  assign out_tuser = head.item_kind;
  assign out_tlast = head.last_of_run;

endmodule

// File: rtl/nsfe_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsfe_step
// Next-state and result logic for one sentence byte.
// ----------------------------------------------------------------------------
module nsfe_step (
  input  nsfe_pkg::kind_t                     kind,
  input  nsfe_pkg::sent_state_t               cur,
  input  logic [nsfe_pkg::ByteW-1:0]          in_char,
  input  logic                                eos,
  output nsfe_pkg::sent_state_t               nxt,
  output nsfe_pkg::result_t                   res [nsfe_pkg::ResultsPerByte],
  output logic [1:0]                          res_cnt
);
  import nsfe_pkg::*;

  logic    is_comma;
  logic    in_header;
  logic    mapped;
  logic    room;
  logic    char_hit;
  logic    tag_ok;
  result_t char_res;
  result_t end_res;
  sent_state_t upd;

  assign is_comma  = (in_char == CharComma);
  assign in_header = (cur.comma_count == '0);
  assign mapped    = field_mapped(kind, cur.comma_count);
  assign room      = (cur.offset_in_field < OffW'(MaxFieldChars));
  assign char_hit  = !is_comma && !in_header && room && mapped;

  // Kind 3 has no tag; position 6 must see the tag terminator
  always_comb begin
    if (cur.header_length < HdrTagLen) begin
      tag_ok = (kind != KIND_UNUSED) && (in_char == tag_char(kind, cur.header_length));
    end else if (cur.header_length == HdrTagLen) begin
      tag_ok = (in_char == 8'h00);
    end else begin
      tag_ok = 1'b1;
    end
  end

  always_comb begin
    upd = cur;
    if (is_comma) begin
      if (cur.comma_count != FieldMax) begin
        upd.comma_count = cur.comma_count + 4'd1;
      end
      upd.offset_in_field = '0;
    end else if (in_header) begin
      if (!tag_ok) begin
        upd.header_still_matches = 1'b0;
      end
      if (cur.header_length != HdrSatLen) begin
        upd.header_length = cur.header_length + 3'd1;
      end
    end else if (room) begin
      upd.offset_in_field = cur.offset_in_field + OffW'(1);
    end else if (mapped) begin
      upd.drop_seen = 1'b1;
    end
  end

  always_comb begin
    char_res              = '0;
    char_res.item_kind    = ITEM_CHAR;
    char_res.field_number = cur.comma_count;
    char_res.char_offset  = cur.offset_in_field[3:0];
    char_res.field_byte   = in_char;
    char_res.last_of_run  = !eos;

    end_res             = '0;
    end_res.item_kind   = ITEM_END;
    end_res.accepted    = upd.header_still_matches && (kind != KIND_UNUSED);
    end_res.overflowed  = upd.drop_seen;
    end_res.last_of_run = 1'b1;
  end

  always_comb begin
    res[0]  = char_hit ? char_res : end_res;
    res[1]  = end_res;
    res_cnt = {1'b0, char_hit} + {1'b0, eos};
    // End of sentence returns the per-sentence state to reset values
    if (eos) begin
      nxt                      = '0;
      nxt.header_still_matches = 1'b1;
    end else begin
      nxt = upd;
    end
  end

endmodule

// File: rtl/nsfe_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsfe_out_queue
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module nsfe_out_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nsfe_pkg::result_t                   push_res [nsfe_pkg::ResultsPerByte],
  input  logic [1:0]                          push_cnt,
  output logic                                room_ok,
  output logic                                head_valid,
  output nsfe_pkg::result_t                   head,
  input  logic                                pop
);
  import nsfe_pkg::*;

  result_t          mem_r [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] count_r,  count_nxt;
  logic             do_pop;

  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;
  // Accept a byte only when both of its possible results fit
  assign room_ok    = (count_r <= QCntW'(QueueDepth - ResultsPerByte));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPtrW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + QPtrW'(do_pop);
    count_nxt  = count_r + QCntW'(push_cnt) - QCntW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push_res[0];
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_r + QPtrW'(1)] <= push_res[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NMEA sentence field extractor.
// ----------------------------------------------------------------------------
// Sentences are pushed into the byte stream with random gaps, and the result
// stream is drained with random back-pressure. A scoreboard class follows the
// header match, the comma count and the per-field offset for every byte that
// is taken, and queues the field characters and end markers that the byte
// should produce. Each result that leaves the block is compared field by
// field with the oldest queued one. The run walks all four sentence kinds,
// with one long receiver hold-off that fills the block's result queue.
// ----------------------------------------------------------------------------
module tb_top;
  import nsfe_pkg::*;

  localparam int PhaseBytes = 140;   // bytes per random phase
  localparam int SettleCyc  = 8;     // result queue depth plus margin
  localparam int QuietLimit = 3000;  // cycles with no transfer before giving up
  localparam int SqueezeCyc = 64;    // long receiver hold-off

  // --------------------------------------------------------------------------
  // Scoreboard: tracks sentence state, queues the expected results
  // --------------------------------------------------------------------------
  class field_book;
    static string tag_of[3] = '{"$GPRMC", "$GPGGA", "$GPVTG"};
    logic [15:0] map_of[4] = '{16'h03FE, 16'h0BFE, 16'h00AA, 16'h0000};

    kind_t       kind;
    logic [3:0]  commas;
    logic [4:0]  offs;
    logic [2:0]  hdr_len;
    logic        hdr_ok;
    logic        dropped;
    result_t     due[$];
    int          errors;

    function new();
      kind   = KIND_RMC;
      errors = 0;
      start_sentence();
    endfunction

    function void start_sentence();
      commas  = '0;
      offs    = '0;
      hdr_len = '0;
      hdr_ok  = 1'b1;
      dropped = 1'b0;
    endfunction

    function void set_kind(kind_t k);
      kind = k;
    endfunction

    function int pending();
      return due.size();
    endfunction

    // Advance the sentence state by one taken byte and queue its results
    function void take_byte(logic [7:0] b, logic eos);
      result_t chr;
      result_t fin;
      logic    have_chr;
      have_chr = 1'b0;
      chr      = '0;
      fin      = '0;
      if (b == CharComma) begin
        if (commas != FieldMax) commas++;
        offs = '0;
      end else if (commas == 0) begin
        // Bounded compare: six tag characters, then the terminator, then nothing
        if (hdr_len < HdrTagLen) begin
          if (kind == KIND_UNUSED || b != tag_of[int'(kind)][hdr_len]) hdr_ok = 1'b0;
        end else if (hdr_len == HdrTagLen) begin
          if (b != 8'h00) hdr_ok = 1'b0;
        end
        if (hdr_len != HdrSatLen) hdr_len++;
      end else if (offs < MaxFieldChars) begin
        if (map_of[int'(kind)][commas]) begin
          have_chr         = 1'b1;
          chr.item_kind    = ITEM_CHAR;
          chr.field_number = commas;
          chr.char_offset  = offs[3:0];
          chr.field_byte   = b;
        end
        offs++;
      end else if (map_of[int'(kind)][commas]) begin
        dropped = 1'b1;
      end

      if (eos) begin
        fin.item_kind   = ITEM_END;
        fin.accepted    = hdr_ok && (kind != KIND_UNUSED);
        fin.overflowed  = dropped;
        fin.last_of_run = 1'b1;
        start_sentence();
      end else begin
        chr.last_of_run = 1'b1;
      end
      if (have_chr) due.push_back(chr);
      if (eos) due.push_back(fin);
    endfunction

    function void cmp_field(string what, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what,
                 exp_v, act_v);
      end
    endfunction

    // Compare one transfer on the result stream with the oldest expectation
    function void match_result(logic [23:0] d, logic u, logic l);
      result_t e;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual tdata=0x%06h tuser=%b tlast=%b",
                 $time, d, u, l);
        return;
      end
      e = due.pop_front();
      cmp_field("item_kind", e.item_kind, u);
      cmp_field("field_number", e.field_number, d[3:0]);
      cmp_field("char_offset", e.char_offset, d[7:4]);
      cmp_field("field_byte", e.field_byte, d[15:8]);
      cmp_field("accepted", e.accepted, d[16]);
      cmp_field("overflowed", e.overflowed, d[17]);
      cmp_field("tdata padding", 0, d[23:18]);
      cmp_field("last_of_run", e.last_of_run, l);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  nmea_sentence_field_extractor_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  field_book   book = new();
  logic [7:0]  sent_q[$];    // bytes of the sentence being built
  int          bytes_sent;
  logic        in_calm;      // sender runs without gaps while set
  logic        out_calm;     // receiver runs without stalls while set
  logic        squeeze_req;  // ask the receiver for the long hold-off
  int          quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] non_comma();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CharComma);
    return c;
  endfunction

  // Mostly printable field text, some arbitrary bytes
  function automatic logic [7:0] field_char();
    logic [7:0] c;
    if ($urandom_range(0, 4) == 0) return non_comma();
    do c = 8'($urandom_range(8'h20, 8'h7E)); while (c == CharComma);
    return c;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) sent_q.push_back(s[i]);
  endfunction

  // Mostly well-formed sentences with random content; the rest is noise,
  // short prefixes, corrupted tags and headers that run past the tag
  function automatic void build_sentence(kind_t k);
    string tag;
    int    sel;
    int    nf;
    int    len;
    int    bad_pos;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 12);
      repeat (len) sent_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    tag     = field_book::tag_of[(k == KIND_UNUSED) ? $urandom_range(0, 2) : int'(k)];
    sel     = $urandom_range(0, 99);
    bad_pos = (sel >= 84 && sel < 92) ? $urandom_range(0, 5) : 6;
    if (sel >= 70 && sel < 78) begin
      len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) sent_q.push_back(tag[i]);
    end else begin
      for (int i = 0; i < 6; i++) sent_q.push_back((i == bad_pos) ? non_comma() : tag[i]);
    end
    if (sel >= 78 && sel < 84) begin
      // Terminator after the tag still matches, anything later is ignored
      sent_q.push_back(8'h00);
      repeat ($urandom_range(0, 3)) sent_q.push_back(non_comma());
    end else if (sel >= 92) begin
      repeat ($urandom_range(1, 2)) sent_q.push_back(non_comma());
    end

    sel = $urandom_range(0, 99);
    nf  = (sel < 70) ? $urandom_range(1, 12) : (sel < 90) ? $urandom_range(13, 18) : 0;
    repeat (nf) begin
      sent_q.push_back(CharComma);
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 5) : $urandom_range(14, 20);
      repeat (len) sent_q.push_back(field_char());
    end
  endfunction

  function automatic int in_gap();
    int r;
    if (in_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Offer one byte at the falling edge, hold it until the rising edge transfer
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = in_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    book.take_byte(b, eos);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send the built sentence, end_of_sentence on its last byte
  task automatic send_sentence();
    if ($urandom_range(0, 4) == 0) in_calm = ~in_calm;
    foreach (sent_q[i]) send_byte(sent_q[i], i == sent_q.size() - 1);
    sent_q.delete();
  endtask

  // Wait until every expected result is out, then let the queue go quiet
  task automatic settle();
    in_tvalid = 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SettleCyc) @(negedge clk);
  endtask

  task automatic write_kind(input kind_t k);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = k;
    book.set_kind(k);
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    kind_t plan[8];
    int    phase_start;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    in_calm     = 1'b0;
    squeeze_req = 1'b0;
    bytes_sent  = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed: full tag with a one-character field ending the sentence
    write_kind(KIND_RMC);
    push_text("$GPRMC,A");
    send_sentence();
    // Empty header matches
    sent_q.push_back(CharComma);
    send_sentence();
    // Single all-ones header byte, rejected, no comma at all
    sent_q.push_back(8'hFF);
    send_sentence();
    // Terminator after the tag, then an unchecked header byte, then a zero byte
    push_text("$GPRMC");
    sent_q.push_back(8'h00);
    sent_q.push_back(8'hFF);
    sent_q.push_back(CharComma);
    sent_q.push_back(8'h00);
    send_sentence();
    settle();

    plan = '{KIND_GGA, KIND_VTG, KIND_UNUSED, KIND_RMC,
             kind_t'($urandom_range(0, 3)), kind_t'($urandom_range(0, 3)),
             kind_t'($urandom_range(0, 3)), kind_t'($urandom_range(0, 3))};
    foreach (plan[p]) begin
      write_kind(plan[p]);
      if (p == 0) begin
        // Keep offering bytes while the receiver holds off
        in_calm     = 1'b1;
        squeeze_req = 1'b1;
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        build_sentence(plan[p]);
        send_sentence();
      end
      settle();
    end

    repeat (16) @(posedge clk);
    if (book.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, calm stretches and one long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int   stall;
    int   r;
    logic squeezed;
    out_tready = 1'b0;
    out_calm   = 1'b0;
    stall      = 0;
    squeezed   = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        stall    = SqueezeCyc;
      end
      if (!rst_n) begin
        out_tready = 1'b0;
      end else if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else begin
        if ($urandom_range(0, 63) == 0) out_calm = ~out_calm;
        r = $urandom_range(0, 99);
        if (out_calm || r < 70) begin
          out_tready = 1'b1;
        end else begin
          out_tready = 1'b0;
          stall      = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 29);
        end
      end
    end
  end

  // Check every result transfer against the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.match_result(out_tdata, out_tuser, out_tlast);
  end

  // Watchdog: give up after a long stretch with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
